// ----- rtl/sppd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the stereo ping-pong delay.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sppd_pkg;

  localparam int HIST_AW    = 16;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int DIFF_W     = SAMPLE_W + 2;
  localparam int FB_SHIFT   = GAIN_W - 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DELAY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DELAY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN  = CFG_IDX_W'(3);

  typedef logic [HIST_AW-1:0]         hist_addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    hist_addr_t left_delay;
    hist_addr_t right_delay;
    gain_t      left_gain;
    gain_t      right_gain;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    sample_t left;
    sample_t right;
  } result_t;

  function automatic hist_addr_t clamp_delay(input logic [DELAY_W-1:0] d);
    hist_addr_t res;
    if (32'(d) > 32'(HIST_DEPTH - 1)) begin
      res = hist_addr_t'(HIST_DEPTH - 1);
    end else begin
      res = hist_addr_t'(d);
    end
    return res;
  endfunction

  // Subtracts the rounded Q1.15 scaled tap from the sample and saturates to 24 bits.
  function automatic sample_t mix_sample(input sample_t x, input gain_t g, input sample_t tap);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [DIFF_W-1:0] fb;
    logic signed [DIFF_W-1:0] diff;
    sample_t                  res;
    prod = PROD_W'(g) * PROD_W'(tap);
    rnd  = prod + PROD_W'(1 << (FB_SHIFT - 1));
    fb   = DIFF_W'(rnd >>> FB_SHIFT);
    diff = DIFF_W'(x) - fb;
    if (diff[DIFF_W-1:SAMPLE_W-1] == '0 || diff[DIFF_W-1:SAMPLE_W-1] == '1) begin
      res = diff[SAMPLE_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      res = SAMPLE_MIN;
    end else begin
      res = SAMPLE_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sppd_cfg_regs.sv -----
// Configuration register file for the delays and gains.
// Depends on sppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sppd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sppd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sppd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sppd_pkg::cfg_t                        cfg
);
  import sppd_pkg::*;

  logic [DELAY_W-1:0] left_delay_r;
  logic [DELAY_W-1:0] right_delay_r;
  gain_t              left_gain_r;
  gain_t              right_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_delay_r  <= '0;
      right_delay_r <= '0;
      left_gain_r   <= '0;
      right_gain_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_DELAY:  left_delay_r  <= DELAY_W'(cfg_data);
        REG_RIGHT_DELAY: right_delay_r <= DELAY_W'(cfg_data);
        REG_LEFT_GAIN:   left_gain_r   <= gain_t'(cfg_data);
        REG_RIGHT_GAIN:  right_gain_r  <= gain_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign cfg.left_delay  = clamp_delay(left_delay_r);
  assign cfg.right_delay = clamp_delay(right_delay_r);
  assign cfg.left_gain   = left_gain_r;
  assign cfg.right_gain  = right_gain_r;

endmodule

`default_nettype wire

// ----- rtl/sppd_engine.sv -----
// Two-stage read-modify-write engine over the left and right history memories.
// Depends on sppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sppd_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sppd_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sppd_pkg::sample_t in_left,
  input  wire sppd_pkg::sample_t in_right,
  output sppd_pkg::result_t      res,
  input  wire logic              res_free
);
  import sppd_pkg::*;

  sample_t left_mem  [HIST_DEPTH];
  sample_t right_mem [HIST_DEPTH];

  logic       acc;
  logic       s1_adv;
  logic       s2_adv;
  hist_addr_t w_r;
  logic       full_r;
  logic       s1_vld_r;
  logic       s2_vld_r;
  hist_addr_t s1_w_r;
  hist_addr_t s1_ra_r;
  hist_addr_t s2_w_r;
  hist_addr_t s2_la_r;
  hist_addr_t s1_la_r;
  logic       s1_full_r;
  logic       s2_full_r;
  sample_t    s1_lin_r;
  sample_t    s1_rin_r;
  sample_t    s2_rin_r;
  sample_t    s2_left_r;
  sample_t    rd_left_r;
  sample_t    rd_right_r;
  logic       lw_vld_r;
  hist_addr_t lw_addr_r;
  sample_t    lw_data_r;
  hist_addr_t ra_nxt;
  hist_addr_t la_nxt;
  sample_t    rtap;
  sample_t    ltap;
  sample_t    left_res;
  sample_t    right_res;

  assign ra_nxt   = w_r - cfg.left_delay;
  assign la_nxt   = w_r + hist_addr_t'(1) - cfg.right_delay;
  assign s2_adv   = s2_vld_r & res_free;
  assign s1_adv   = s1_vld_r & (~s2_vld_r | s2_adv);
  assign in_stall = s1_vld_r | (s2_vld_r & ~res_free);
  assign acc      = in_valid & ~in_stall;

  // Entries at or beyond the write position that have never been written read as zero.
  always_comb begin
    if (lw_vld_r && s1_ra_r == lw_addr_r) begin
      rtap = lw_data_r;
    end else if (s1_full_r || s1_ra_r < s1_w_r) begin
      rtap = rd_right_r;
    end else begin
      rtap = '0;
    end
    left_res = mix_sample(s1_lin_r, cfg.left_gain, rtap);
  end

  always_comb begin
    if (s2_la_r == s2_w_r) begin
      ltap = s2_left_r;
    end else if (s2_full_r || s2_la_r < s2_w_r) begin
      ltap = rd_left_r;
    end else begin
      ltap = '0;
    end
    right_res = mix_sample(s2_rin_r, cfg.right_gain, ltap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= '0;
      full_r   <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      lw_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc | (s1_vld_r & ~s1_adv);
      s2_vld_r <= s1_adv | (s2_vld_r & ~s2_adv);
      if (acc) begin
        w_r <= w_r + hist_addr_t'(1);
        if (w_r == hist_addr_t'(HIST_DEPTH - 1)) begin
          full_r <= 1'b1;
        end
      end
      if (s2_adv) begin
        lw_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_w_r    <= w_r;
      s1_full_r <= full_r;
      s1_ra_r   <= ra_nxt;
      s1_la_r   <= la_nxt;
      s1_lin_r  <= in_left;
      s1_rin_r  <= in_right;
    end
    if (s1_adv) begin
      s2_w_r    <= s1_w_r;
      s2_full_r <= s1_full_r;
      s2_la_r   <= s1_la_r;
      s2_rin_r  <= s1_rin_r;
      s2_left_r <= left_res;
    end
    if (s2_adv) begin
      lw_addr_r <= s2_w_r;
      lw_data_r <= right_res;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_left_r <= left_mem[la_nxt];
    end
    if (s1_adv) begin
      left_mem[s1_w_r] <= left_res;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_right_r <= right_mem[ra_nxt];
    end
    if (s2_adv) begin
      right_mem[s2_w_r] <= right_res;
    end
  end

  assign res.valid = s2_vld_r;
  assign res.left  = s2_left_r;
  assign res.right = right_res;

endmodule

`default_nettype wire

// ----- rtl/stereo_ping_pong_delay_unit.sv -----
// Stereo ping-pong delay: an accepted input transaction passes two engine stages
// and the output register; the next is not taken while it is in the first stage
// due to the left-to-right-to-left feedback loop through both history memories.
// Synchronous reset clears control state and delays/gains; the histories need no
// clearing pass, as a fill count makes entries not yet written read as zero.
`timescale 1ns / 1ps
`default_nettype none

module stereo_ping_pong_delay_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sppd_pkg::sample_t                in_left_in,
  input  wire sppd_pkg::sample_t                in_right_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sppd_pkg::sample_t                     out_left_out,
  output sppd_pkg::sample_t                     out_right_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sppd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sppd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sppd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_free;
  logic    out_valid_r;
  sample_t out_left_r;
  sample_t out_right_r;

  sppd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sppd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_left  (in_left_in),
    .in_right (in_right_in),
    .res      (res),
    .res_free (res_free)
  );

  assign res_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      out_left_r  <= res.left;
      out_right_r <= res.right;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

`ifndef SYNTHESIS
  a_two_cycle_spacing : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transaction accepted in consecutive cycles");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_free) |=> (res.valid && $stable(res.left) && $stable(res.right)))
    else $error("pending result changed while output register was blocked");

  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_free) |-> in_stall)
    else $error("input accepted while a result was blocked");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for stereo_ping_pong_delay_unit: random and directed stereo
// transactions checked against a cycle-free predictor of the cross-feedback delay.
// Depends on sppd_pkg and the unit itself.
`timescale 1ns / 1ps

module tb;
  import sppd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CFG_IDX_MAX = (1 << CFG_IDX_W) - 1;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_left_in = '0;
  sample_t in_right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_left_out;
  sample_t out_right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stereo_pair_t pending_pairs[$];
  stereo_pair_t expected_pairs[$];

  bit signed [SAMPLE_W-1:0] left_hist [HIST_DEPTH];
  bit signed [SAMPLE_W-1:0] right_hist [HIST_DEPTH];
  int write_pos = 0;
  logic [DELAY_W-1:0] left_delay_r = '0;
  logic [DELAY_W-1:0] right_delay_r = '0;
  gain_t left_gain_r = '0;
  gain_t right_gain_r = '0;

  bit input_taken;
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int error_count = 0;
  int cycle_count = 0;

  stereo_ping_pong_delay_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int clamp_tap(input logic [DELAY_W-1:0] d);
    return (int'(d) > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : int'(d);
  endfunction

  // Rounds the Q1.15 scaled tap half up to Q1.23, subtracts it and saturates.
  function automatic sample_t feedback_mix(input sample_t x, input gain_t g, input sample_t tap);
    longint prod;
    longint acc;
    prod = longint'(g) * longint'(tap) + 64'sd16384;
    acc = longint'(x) - (prod >>> 15);
    if (acc > longint'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (acc < longint'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return sample_t'(acc);
  endfunction

  function automatic stereo_pair_t ping_pong_predict(input stereo_pair_t x);
    stereo_pair_t y;
    int rd_l;
    int rd_r;
    rd_l = (write_pos + HIST_DEPTH - clamp_tap(left_delay_r)) % HIST_DEPTH;
    y.left = feedback_mix(x.left, left_gain_r, right_hist[rd_l]);
    left_hist[write_pos] = y.left;
    rd_r = (write_pos + 1 + HIST_DEPTH - clamp_tap(right_delay_r)) % HIST_DEPTH;
    y.right = feedback_mix(x.right, right_gain_r, left_hist[rd_r]);
    right_hist[write_pos] = y.right;
    write_pos = (write_pos + 1) % HIST_DEPTH;
    return y;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || input_taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_left_in <= pending_pairs[0].left;
        in_right_in <= pending_pairs[0].right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin : monitor
    stereo_pair_t got;
    stereo_pair_t want;
    input_taken = rst_n && in_valid && !in_stall;
    if (input_taken) begin
      got.left = in_left_in;
      got.right = in_right_in;
      expected_pairs.push_back(ping_pong_predict(got));
      pending_pairs.pop_front();
      items_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_pairs.size() == 0) begin
        $error("Unexpected output transaction: left_out %0d, right_out %0d",
               out_left_out, out_right_out);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_left_out !== want.left) begin
          $error("left_out: expected %0d, actual %0d", want.left, out_left_out);
          error_count++;
        end
        if (out_right_out !== want.right) begin
          $error("right_out: expected %0d, actual %0d", want.right, out_right_out);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LEFT_DELAY:  left_delay_r = val;
      REG_RIGHT_DELAY: right_delay_r = val;
      REG_LEFT_GAIN:   left_gain_r = gain_t'(val);
      REG_RIGHT_GAIN:  right_gain_r = gain_t'(val);
      default: begin
      end
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [DELAY_W-1:0] dl, input logic [DELAY_W-1:0] dr,
                                input gain_t gl, input gain_t gr);
    write_reg(REG_LEFT_DELAY, dl);
    write_reg(REG_RIGHT_DELAY, dr);
    write_reg(REG_LEFT_GAIN, gl);
    write_reg(REG_RIGHT_GAIN, gr);
  endtask

  task automatic queue_pair(input sample_t l, input sample_t r);
    stereo_pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs.push_back(p);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_pairs.size() != 0 || expected_pairs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(7))
      0: return '0;
      1: return DELAY_W'(1);
      2: return '1;
      3: return DELAY_W'($urandom_range(300));
      4: return DELAY_W'($urandom_range(2000));
      5: return DELAY_W'($urandom);
      default: return DELAY_W'($urandom_range(40, 2));
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(5))
      0: return gain_t'(32767);
      1: return gain_t'(-32768);
      2: return gain_t'(int'($urandom_range(511)) - 256);
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(1023)) - 512);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n, input int idle_pct, input int stall_p,
                            input bit with_pause);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_p;
    apply_settings(pick_delay(), pick_delay(), pick_gain(), pick_gain());
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, REG_RIGHT_GAIN + 1)),
                CFG_DATA_W'($urandom));
    end
    for (int i = 0; i < n; i++) begin
      queue_pair(random_sample(), random_sample());
      if (with_pause && i == n / 2) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset values: outputs follow the inputs.
    queue_pair('0, '0);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(sample_t'(1), sample_t'(-1));
    queue_pair(sample_t'(-1), sample_t'(1));
    wait_idle();

    // Unit delays with gain extremes drive both channels into saturation.
    apply_settings(DELAY_W'(1), DELAY_W'(1), gain_t'(32767), gain_t'(-32768));
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    queue_pair(SAMPLE_MIN, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair('0, '0);
    wait_idle();

    // Zero delays read the oldest entries; writes to unused indexes must change nothing.
    apply_settings('0, '0, gain_t'(-32768), gain_t'(-32768));
    write_reg(CFG_IDX_W'(REG_RIGHT_GAIN + 1), '1);
    write_reg(CFG_IDX_W'(CFG_IDX_MAX), CFG_DATA_W'(16'h1234));
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(sample_t'(4096), sample_t'(-4096));
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    wait_idle();

    apply_settings('1, '1, gain_t'(32767), gain_t'(32767));
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(sample_t'(12345), sample_t'(-54321));
    wait_idle();

    apply_settings(DELAY_W'(2), DELAY_W'(3), gain_t'(-32768), gain_t'(32767));
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    queue_pair(SAMPLE_MIN, SAMPLE_MIN);
    queue_pair(sample_t'(-777), sample_t'(999));
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair('0, '0);
    wait_idle();

    run_random(220, 0, 0, 1'b0);
    run_random(220, 0, 0, 1'b1);
    run_random(220, 54, 0, 1'b0);
    run_random(220, 54, 0, 1'b0);
    run_random(220, 0, 54, 1'b0);
    run_random(220, 0, 54, 1'b1);
    run_random(220, 36, 36, 1'b0);
    run_random(220, 36, 36, 1'b0);

    $display("Run covered %0d input and %0d output transactions with %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("across zero, unit and full-depth delays, gain extremes and mixed back-pressure.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
